[sv/gcl_pkg.sv]
// Shared types, status codes and the microcode ROM of the GCD/LCM unit.
// No dependencies; used by gcl_sequencer and gcd_lcm_unit.
package gcl_pkg;

  localparam int unsigned PC_W  = 3;
  localparam int unsigned MAG_W = 31;
  localparam int unsigned LCM_W = 62;
  localparam int unsigned CNT_W = 5;

  localparam logic [1:0] ST_NONE = 2'd0;  // both operands zero
  localparam logic [1:0] ST_ONE  = 2'd1;  // one operand zero, no LCM
  localparam logic [1:0] ST_BOTH = 2'd2;  // GCD and LCM valid

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_STEIN,
    OP_FORM_G,
    OP_DIV,
    OP_MUL,
    OP_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_ZERO,
    COND_XY_NE,
    COND_CNT,
    COND_OUT
  } cond_t;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic zero_any;
    logic xy_ne;
    logic cnt_nz;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic busy;
    op_t  op;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_START = PC_W'(0);
  localparam logic [PC_W-1:0] PC_STEIN = PC_W'(1);
  localparam logic [PC_W-1:0] PC_DIV   = PC_W'(3);
  localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(5);
  localparam logic [PC_W-1:0] PC_ZERO  = PC_W'(6);

  // The program: zero check, binary GCD loop, scale GCD, divide, multiply,
  // hand the item over. The zero path rejoins at the hand-over word.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_JUMP, target: PC_START};
    case (pc)
      3'd0: w = '{op: OP_NOP,    cond: COND_ZERO,  target: PC_ZERO};
      3'd1: w = '{op: OP_STEIN,  cond: COND_XY_NE, target: PC_STEIN};
      3'd2: w = '{op: OP_FORM_G, cond: COND_NEXT,  target: PC_START};
      3'd3: w = '{op: OP_DIV,    cond: COND_CNT,   target: PC_DIV};
      3'd4: w = '{op: OP_MUL,    cond: COND_NEXT,  target: PC_START};
      3'd5: w = '{op: OP_EMIT,   cond: COND_OUT,   target: PC_START};
      3'd6: w = '{op: OP_ZERO,   cond: COND_JUMP,  target: PC_EMIT};
      default: w = '{op: OP_NOP, cond: COND_JUMP,  target: PC_START};
    endcase
    return w;
  endfunction

endpackage

[sv/gcl_sequencer.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on gcl_pkg.
module gcl_sequencer
  import gcl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy;
  logic            busy_next;
  uword_t          word;

  assign word = ucode_rom(pc);
  assign ctrl.busy = busy;
  assign ctrl.op   = busy ? word.op : OP_NOP;

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = PC_START;
      busy_next = 1'b1;
    end else if (busy) begin
      unique case (word.cond)
        COND_NEXT:  pc_next = pc + PC_W'(1);
        COND_JUMP:  pc_next = word.target;
        COND_ZERO:  pc_next = flags.zero_any ? word.target : pc + PC_W'(1);
        COND_XY_NE: pc_next = flags.xy_ne ? word.target : pc + PC_W'(1);
        COND_CNT:   pc_next = flags.cnt_nz ? word.target : pc + PC_W'(1);
        COND_OUT: begin
          // The item leaves only once the output register is free.
          if (flags.out_free) begin
            pc_next   = word.target;
            busy_next = 1'b0;
          end
        end
        default:    pc_next = PC_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_START;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

[sv/gcd_lcm_unit.sv]
// GCD and LCM of the magnitudes of two signed 32-bit operands, one result item per input item.
// Takes one item at a time: each item runs through the binary GCD loop
// (at most 62 steps, one per cycle) followed by a 31-step restoring divide and one multiply,
// all run by a microcoded sequencer over a single datapath. A finished result waits in an
// output register, so the next item can be accepted while it is still unclaimed.
// The pattern 0x80000000 is treated as -2147483647. Depends on gcl_pkg and gcl_sequencer.
module gcd_lcm_unit
  import gcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] a_value,
  input  logic signed [31:0] b_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [MAG_W-1:0]  gcd_value,
  output logic [LCM_W-1:0]  lcm_value
);

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  logic [MAG_W-1:0] ma;
  logic [MAG_W-1:0] mb;
  logic [MAG_W-1:0] x;
  logic [MAG_W-1:0] y;
  logic [CNT_W-1:0] k;
  logic [MAG_W-1:0] g;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [LCM_W-1:0] lcm;
  logic [1:0]       res_status;

  logic [MAG_W-1:0] mag_a;
  logic [MAG_W-1:0] mag_b;

  function automatic logic [MAG_W-1:0] magnitude(input logic [31:0] v);
    logic [31:0] n;
    n = v[31] ? (32'd0 - v) : v;
    // Only the most negative pattern leaves bit 31 set; it saturates.
    return n[31] ? {MAG_W{1'b1}} : n[MAG_W-1:0];
  endfunction

  assign mag_a = magnitude(a_value);
  assign mag_b = magnitude(b_value);

  assign accept   = in_valid && in_ready;
  assign in_ready = !ctrl.busy;

  assign flags.zero_any = (x == '0) || (y == '0);
  assign flags.xy_ne    = (x != y);
  assign flags.cnt_nz   = (cnt != '0);
  assign flags.out_free = !out_valid || out_ready;

  gcl_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Restoring divide step and the product.
  logic [MAG_W:0]   rem_sh;
  logic             div_ge;
  logic [LCM_W-1:0] product;

  assign rem_sh  = {rem, quo[MAG_W-1]};
  assign div_ge  = rem_sh >= {1'b0, g};
  assign product = LCM_W'(quo) * LCM_W'(mb);

  logic emit_fire;
  assign emit_fire = (ctrl.op == OP_EMIT) && flags.out_free;

  always_ff @(posedge clk) begin
    if (accept) begin
      ma <= mag_a;
      mb <= mag_b;
      x  <= mag_a;
      y  <= mag_b;
      k  <= '0;
    end else begin
      unique case (ctrl.op)
        OP_NOP, OP_EMIT: begin
        end
        OP_STEIN: begin
          if (flags.xy_ne) begin
            if (!x[0] && !y[0]) begin
              x <= x >> 1;
              y <= y >> 1;
              k <= k + CNT_W'(1);
            end else if (!x[0]) begin
              x <= x >> 1;
            end else if (!y[0]) begin
              y <= y >> 1;
            end else if (x > y) begin
              x <= (x - y) >> 1;
            end else begin
              y <= (y - x) >> 1;
            end
          end
        end
        OP_FORM_G: begin
          g   <= x << k;
          rem <= '0;
          quo <= ma;
          cnt <= DIV_LAST;
        end
        OP_DIV: begin
          rem <= div_ge ? MAG_W'(rem_sh - {1'b0, g}) : rem_sh[MAG_W-1:0];
          quo <= {quo[MAG_W-2:0], div_ge};
          cnt <= cnt - CNT_W'(1);
        end
        OP_MUL: begin
          lcm        <= product;
          res_status <= ST_BOTH;
        end
        OP_ZERO: begin
          // At most one of x and y is nonzero here.
          g          <= x | y;
          lcm        <= '0;
          res_status <= ((x == '0) && (y == '0)) ? ST_NONE : ST_ONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_fire || (out_valid && !out_ready);
    end
    if (emit_fire) begin
      status    <= res_status;
      gcd_value <= g;
      lcm_value <= lcm;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("unit took an item but did not go busy");

  assert property (@(posedge clk) disable iff (rst)
      (ctrl.op == OP_DIV) |-> ({1'b0, rem} < {1'b0, g}))
    else $error("partial remainder not below the divisor");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && (status == ST_NONE)) |-> ((gcd_value == '0) && (lcm_value == '0)))
    else $error("both-zero result carries nonzero values");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && (status == ST_BOTH)) |-> ((gcd_value != '0) && (lcm_value != '0)))
    else $error("normal result with a zero GCD or LCM");

endmodule
